// ----- src/fixed_point_iir_section_macros.svh -----
// Assertion macros for the fixed-point IIR section.
`ifndef FIXED_POINT_IIR_SECTION_MACROS_SVH
`define FIXED_POINT_IIR_SECTION_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FPIIR_ASSERT(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("fpiir assertion failed");
`define FPIIR_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpiir assertion failed");
`define FPIIR_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpiir assertion failed");
`else
`define FPIIR_ASSERT(name, cond)
`define FPIIR_ASSERT_IMP(name, ante, cons)
`define FPIIR_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ----- src/fpiir_pkg.sv -----
// Package: widths, register map, reset values and control types of the IIR section.
package fpiir_pkg;

	localparam int ORDER        = 4;
	localparam int SAMPLE_WIDTH = 16;
	localparam int STATE_WIDTH  = 40;

	localparam int COEF_WIDTH = 16;
	localparam int FRAC_WIDTH = 4;
	localparam int WORD_WIDTH = 32;
	localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
	localparam int ACC_WIDTH  = ((STATE_WIDTH > PROD_WIDTH) ? STATE_WIDTH : PROD_WIDTH) + 1;
	localparam int IDX_WIDTH  = (ORDER > 2) ? $clog2(ORDER) : 1;

	localparam int NUM_REGS     = 8;
	localparam int CFG_IDX_WIDTH = $clog2(NUM_REGS);
	localparam int CFG_DATA_WIDTH = WORD_WIDTH;

	localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(ORDER - 1);

	localparam logic signed [ACC_WIDTH-1:0] SAT_MAX =
		ACC_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [ACC_WIDTH-1:0] SAT_MIN =
		ACC_WIDTH'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_B0    = 3'd0,
		REG_B1    = 3'd1,
		REG_B2    = 3'd2,
		REG_B3    = 3'd3,
		REG_B4    = 3'd4,
		REG_A1_A2 = 3'd5,
		REG_A3_A4 = 3'd6,
		REG_FRAC  = 3'd7
	} reg_idx_t;

	localparam logic signed [COEF_WIDTH-1:0] RST_B0 = 16'sd26;
	localparam logic signed [COEF_WIDTH-1:0] RST_B1 = 16'sd105;
	localparam logic signed [COEF_WIDTH-1:0] RST_B2 = 16'sd158;
	localparam logic signed [COEF_WIDTH-1:0] RST_B3 = 16'sd105;
	localparam logic signed [COEF_WIDTH-1:0] RST_B4 = 16'sd26;
	localparam logic [WORD_WIDTH-1:0] RST_A1_A2 = 32'h5384_AE76;
	localparam logic [WORD_WIDTH-1:0] RST_A3_A4 = 32'h0743_D86A;
	localparam logic [FRAC_WIDTH-1:0] RST_FRAC  = 4'd13;

	typedef struct packed {
		logic signed [COEF_WIDTH-1:0] b0;
		logic signed [COEF_WIDTH-1:0] b1;
		logic signed [COEF_WIDTH-1:0] b2;
		logic signed [COEF_WIDTH-1:0] b3;
		logic signed [COEF_WIDTH-1:0] b4;
		logic [WORD_WIDTH-1:0]        a12;
		logic [WORD_WIDTH-1:0]        a34;
		logic [FRAC_WIDTH-1:0]        frac;
	} cfg_t;

	typedef enum logic [3:0] {
		C_B0 = 4'd0,
		C_B1 = 4'd1,
		C_B2 = 4'd2,
		C_B3 = 4'd3,
		C_B4 = 4'd4,
		C_A1 = 4'd5,
		C_A2 = 4'd6,
		C_A3 = 4'd7,
		C_A4 = 4'd8
	} coef_sel_t;

	typedef struct packed {
		logic                 capture_u;
		logic                 mul_en;
		coef_sel_t            mul_coef;
		logic                 mul_use_y;
		logic                 acc0_load;
		logic                 div_en;
		logic                 sat_en;
		logic                 upd_add;
		logic                 upd_sub;
		logic [IDX_WIDTH-1:0] idx;
	} cmd_t;

endpackage

// ----- src/fpiir_if.sv -----
// Valid/ready channel interfaces for input samples and filtered results.
interface fpiir_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [fpiir_pkg::SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface fpiir_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [fpiir_pkg::SAMPLE_WIDTH-1:0] sample_out;
	logic                                    clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// ----- src/fpiir_regs.sv -----
// Configuration register file: coefficients and output shift.
module fpiir_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [fpiir_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [fpiir_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
	output fpiir_pkg::cfg_t                       cfg
);
	import fpiir_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.b0   <= RST_B0;
			cfg_q.b1   <= RST_B1;
			cfg_q.b2   <= RST_B2;
			cfg_q.b3   <= RST_B3;
			cfg_q.b4   <= RST_B4;
			cfg_q.a12  <= RST_A1_A2;
			cfg_q.a34  <= RST_A3_A4;
			cfg_q.frac <= RST_FRAC;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_B0:    cfg_q.b0   <= cfg_wdata[COEF_WIDTH-1:0];
				REG_B1:    cfg_q.b1   <= cfg_wdata[COEF_WIDTH-1:0];
				REG_B2:    cfg_q.b2   <= cfg_wdata[COEF_WIDTH-1:0];
				REG_B3:    cfg_q.b3   <= cfg_wdata[COEF_WIDTH-1:0];
				REG_B4:    cfg_q.b4   <= cfg_wdata[COEF_WIDTH-1:0];
				REG_A1_A2: cfg_q.a12  <= cfg_wdata[WORD_WIDTH-1:0];
				REG_A3_A4: cfg_q.a34  <= cfg_wdata[WORD_WIDTH-1:0];
				REG_FRAC:  cfg_q.frac <= cfg_wdata[FRAC_WIDTH-1:0];
				default:   cfg_q      <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/fpiir_dp.sv -----
// Datapath: shared multiplier, accumulator, output scaling and filter state.
module fpiir_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  fpiir_pkg::cfg_t                        cfg,
	input  fpiir_pkg::cmd_t                        cmd,
	input  logic signed [fpiir_pkg::SAMPLE_WIDTH-1:0] sample_in,
	output logic signed [fpiir_pkg::SAMPLE_WIDTH-1:0] sample_out,
	output logic                                   clipped
);
	import fpiir_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] u_q;
	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic signed [PROD_WIDTH-1:0]   prod_q;
	logic signed [ACC_WIDTH-1:0]    acc_q;
	logic signed [ACC_WIDTH-1:0]    ydiv_q;
	logic signed [STATE_WIDTH-1:0]  state_q [ORDER];
	logic signed [SAMPLE_WIDTH-1:0] out_q;
	logic                           clip_q;

	logic signed [COEF_WIDTH-1:0]   coef;
	logic signed [SAMPLE_WIDTH-1:0] mul_op;
	logic [IDX_WIDTH-1:0]           nxt_idx;
	logic signed [STATE_WIDTH-1:0]  upd_state;
	logic signed [ACC_WIDTH-1:0]    bias;
	logic signed [ACC_WIDTH-1:0]    acc_biased;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;
	logic                           y_clip;
	logic signed [STATE_WIDTH-1:0]  sub_res;

	always_comb begin
		unique case (cmd.mul_coef)
			C_B0:    coef = cfg.b0;
			C_B1:    coef = cfg.b1;
			C_B2:    coef = cfg.b2;
			C_B3:    coef = cfg.b3;
			C_B4:    coef = cfg.b4;
			C_A1:    coef = cfg.a12[COEF_WIDTH-1:0];
			C_A2:    coef = cfg.a12[WORD_WIDTH-1:COEF_WIDTH];
			C_A3:    coef = cfg.a34[COEF_WIDTH-1:0];
			C_A4:    coef = cfg.a34[WORD_WIDTH-1:COEF_WIDTH];
			default: coef = '0;
		endcase
	end

	assign mul_op  = cmd.mul_use_y ? y_q : u_q;
	assign nxt_idx = cmd.idx + IDX_WIDTH'(1);
	assign upd_state = (cmd.idx == LAST_IDX) ? '0 : state_q[nxt_idx];

	// truncation toward zero: bias negative values by 2^frac - 1
	assign bias = acc_q[ACC_WIDTH-1] ?
		((ACC_WIDTH'(1) <<< cfg.frac) - ACC_WIDTH'(1)) : '0;
	assign acc_biased = acc_q + bias;

	always_comb begin
		priority if (ydiv_q > SAT_MAX) begin
			y_sat  = SAT_MAX[SAMPLE_WIDTH-1:0];
			y_clip = 1'b1;
		end else if (ydiv_q < SAT_MIN) begin
			y_sat  = SAT_MIN[SAMPLE_WIDTH-1:0];
			y_clip = 1'b1;
		end else begin
			y_sat  = ydiv_q[SAMPLE_WIDTH-1:0];
			y_clip = 1'b0;
		end
	end

	assign sub_res = acc_q[STATE_WIDTH-1:0] - STATE_WIDTH'(prod_q);

	always_ff @(posedge clk) begin
		if (cmd.capture_u) begin
			u_q <= sample_in;
		end
		if (cmd.mul_en) begin
			prod_q <= PROD_WIDTH'(coef) * PROD_WIDTH'(mul_op);
		end
		if (cmd.acc0_load) begin
			acc_q <= ACC_WIDTH'(state_q[0]) + ACC_WIDTH'(prod_q);
		end else if (cmd.upd_add) begin
			acc_q <= ACC_WIDTH'(upd_state) + ACC_WIDTH'(prod_q);
		end
		if (cmd.div_en) begin
			ydiv_q <= acc_biased >>> cfg.frac;
		end
		if (cmd.sat_en) begin
			y_q    <= y_sat;
			out_q  <= y_sat;
			clip_q <= y_clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORDER; i++) begin
				state_q[i] <= '0;
			end
		end else if (cmd.upd_sub) begin
			state_q[cmd.idx] <= sub_res;
		end
	end

	assign sample_out = out_q;
	assign clipped    = clip_q;

endmodule

// ----- src/fpiir_ctrl.sv -----
// Controller: sequences one sample through the shared multiplier and state updates.
module fpiir_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output fpiir_pkg::cmd_t cmd
);
	import fpiir_pkg::*;

	`include "fixed_point_iir_section_macros.svh"

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_B0   = 7'b0000010,
		ST_ACC0 = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_SAT  = 7'b0010000,
		ST_ADD  = 7'b0100000,
		ST_SUB  = 7'b1000000
	} state_t;

	localparam logic [3:0] B_NEXT_OFS = 4'd2;

	state_t               state_q, state_d;
	logic [IDX_WIDTH-1:0] k_q, k_d;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 accept;
	logic                 last_k;

	assign out_free = !out_valid_q || out_ready;
	assign last_k   = (k_q == LAST_IDX);
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_SUB) && last_k);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d       = state_q;
		k_d           = k_q;
		cmd           = '0;
		cmd.mul_coef  = C_B0;
		cmd.idx       = k_q;
		cmd.capture_u = accept;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_B0;
				end
			end
			ST_B0: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_coef = C_B0;
				state_d      = ST_ACC0;
			end
			ST_ACC0: begin
				cmd.acc0_load = 1'b1;
				cmd.mul_en    = 1'b1;
				cmd.mul_coef  = C_B1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_en = 1'b1;
				state_d    = ST_SAT;
			end
			ST_SAT: begin
				if (out_free) begin
					cmd.sat_en = 1'b1;
					k_d        = '0;
					state_d    = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.upd_add   = 1'b1;
				cmd.mul_en    = 1'b1;
				cmd.mul_use_y = 1'b1;
				cmd.mul_coef  = coef_sel_t'(4'(C_A1) + 4'(k_q));
				state_d       = ST_SUB;
			end
			ST_SUB: begin
				cmd.upd_sub = 1'b1;
				if (last_k) begin
					k_d     = '0;
					state_d = accept ? ST_B0 : ST_IDLE;
				end else begin
					cmd.mul_en   = 1'b1;
					cmd.mul_coef = coef_sel_t'(4'(C_B0) + 4'(k_q) + B_NEXT_OFS);
					k_d          = k_q + IDX_WIDTH'(1);
					state_d      = ST_ADD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (cmd.sat_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`FPIIR_ASSERT_IMP(a_accept_when_free, in_valid && in_ready,
		state_q == ST_IDLE || (state_q == ST_SUB && k_q == LAST_IDX))
	`FPIIR_ASSERT_IMP(a_result_from_sat, $rose(out_valid_q), $past(state_q) == ST_SAT)
	`FPIIR_ASSERT_NXT(a_sat_holds, state_q == ST_SAT && out_valid_q && !out_ready,
		state_q == ST_SAT)
	`FPIIR_ASSERT(a_k_clear_at_start, state_q != ST_B0 || k_q == '0)

endmodule

// ----- src/fixed_point_iir_section.sv -----
// Top level of the order-4 fixed-point IIR section (transposed direct form II).
//
// Usage:
//   in_ch  : valid/ready channel carrying one signed 16-bit sample per transaction.
//   out_ch : valid/ready channel carrying the filtered signed 16-bit sample and a clip flag.
//   cfg_*  : write-only port; cfg_index selects b0..b4, a1/a2, a3/a4, frac_bits.
//            Write only while no sample is in flight.
// Sequence:
//   The output path runs the states B0 (b0*u), ACC0 (add s0), DIV (frac
//   shift) and SAT (saturate into the output register); then each state
//   word is updated in an ADD and a SUB state, all through one shared 16x16
//   multiplier. The next sample can be taken on the last update cycle.
// Reset:
//   arst_n clears the filter state to zero and loads the low-pass
//   coefficients with 13 fractional bits.
// Backpressure:
//   The output register holds one result; if it is still occupied when the
//   next result is ready, the block waits until out_ch accepts it.
module fixed_point_iir_section (
	input  logic                                  clk,
	input  logic                                  arst_n,
	fpiir_in_if.sink                              in_ch,
	fpiir_out_if.source                           out_ch,
	input  logic                                  cfg_we,
	input  logic [fpiir_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [fpiir_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);
	import fpiir_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	fpiir_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	fpiir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	fpiir_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.sample_in  (in_ch.sample_in),
		.sample_out (out_ch.sample_out),
		.clipped    (out_ch.clipped)
	);

endmodule

// ----- tb/tb.sv -----
// Testbench for fixed_point_iir_section: directed and random samples checked against a filter predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fpiir_pkg::*;

	localparam int SETTLE_CYCLES    = 16;
	localparam int STUCK_LIMIT      = 2000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS      = 90;
	localparam int BURST_ITEMS      = 40;

	typedef enum int {
		STYLE_LOWPASS,
		STYLE_FIR,
		STYLE_MILD,
		STYLE_EXTREME,
		STYLE_WILD
	} coef_style_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           clipped;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_WIDTH-1:0]  cfg_index;
	logic [CFG_DATA_WIDTH-1:0] cfg_wdata;

	fpiir_in_if  in_ch ();
	fpiir_out_if out_ch ();

	fixed_point_iir_section dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	cfg_t                          coefs;
	logic signed [STATE_WIDTH-1:0] tap_state [ORDER];
	result_t                       pending_outputs [$];
	int                            mismatches = 0;
	int                            stuck_cycles = 0;
	int                            long_hold = 0;
	bit                            sender_idle = 1'b0;
	bit                            receiver_idle = 1'b0;

	always #1 clk = ~clk;

	function automatic cfg_t lowpass_coefs();
		cfg_t c;
		c.b0   = RST_B0;
		c.b1   = RST_B1;
		c.b2   = RST_B2;
		c.b3   = RST_B3;
		c.b4   = RST_B4;
		c.a12  = RST_A1_A2;
		c.a34  = RST_A3_A4;
		c.frac = RST_FRAC;
		return c;
	endfunction

	function automatic logic signed [COEF_WIDTH-1:0] rand_coef(input int mag);
		int v;
		v = int'($urandom_range(0, 2 * mag)) - mag;
		return v[COEF_WIDTH-1:0];
	endfunction

	function automatic logic signed [COEF_WIDTH-1:0] extreme_coef();
		case ($urandom_range(0, 2))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return 16'sh0000;
		endcase
	endfunction

	function automatic cfg_t random_coefs(input coef_style_t style);
		cfg_t c;
		int mag;
		c = lowpass_coefs();
		case (style)
			STYLE_FIR: begin
				c.frac = 4'd15;
				c.b0 = rand_coef(16384);
				c.b1 = rand_coef(16384);
				c.b2 = rand_coef(16384);
				c.b3 = rand_coef(16384);
				c.b4 = rand_coef(16384);
				c.a12 = '0;
				c.a34 = '0;
			end
			STYLE_MILD: begin
				c.frac = FRAC_WIDTH'($urandom_range(10, 15));
				mag = 1 << (c.frac - 2);
				c.b0 = rand_coef(mag);
				c.b1 = rand_coef(mag);
				c.b2 = rand_coef(mag);
				c.b3 = rand_coef(mag);
				c.b4 = rand_coef(mag);
				c.a12 = {rand_coef(mag / 2), rand_coef(mag / 2)};
				c.a34 = {rand_coef(mag / 2), rand_coef(mag / 2)};
			end
			STYLE_EXTREME: begin
				c.frac = $urandom_range(0, 1) ? 4'd15 : 4'd0;
				c.b0 = extreme_coef();
				c.b1 = extreme_coef();
				c.b2 = extreme_coef();
				c.b3 = extreme_coef();
				c.b4 = extreme_coef();
				c.a12 = {extreme_coef(), extreme_coef()};
				c.a34 = {extreme_coef(), extreme_coef()};
			end
			STYLE_WILD: begin
				c.frac = FRAC_WIDTH'($urandom_range(0, 15));
				c.b0 = COEF_WIDTH'($urandom());
				c.b1 = COEF_WIDTH'($urandom());
				c.b2 = COEF_WIDTH'($urandom());
				c.b3 = COEF_WIDTH'($urandom());
				c.b4 = COEF_WIDTH'($urandom());
				c.a12 = $urandom();
				c.a34 = $urandom();
			end
			default: ;
		endcase
		return c;
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample(
		input logic signed [SAMPLE_WIDTH-1:0] prev);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return SAMPLE_WIDTH'($urandom());
		else if (pick < 70)
			return SAMPLE_WIDTH'(int'($urandom_range(0, 512)) - 256);
		else if (pick < 85) begin
			case ($urandom_range(0, 4))
				0: return 16'sh7FFF;
				1: return 16'sh8000;
				2: return 16'sh0000;
				3: return 16'sh0001;
				default: return 16'shFFFF;
			endcase
		end
		return prev;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// One filter step: output from b0*u + s0, then the transposed state update.
	task automatic predict_section_output(input logic signed [SAMPLE_WIDTH-1:0] u);
		logic signed [COEF_WIDTH-1:0] b [ORDER+1];
		logic signed [COEF_WIDTH-1:0] a [ORDER+1];
		longint uu;
		longint acc;
		longint y;
		result_t res;
		b[0] = coefs.b0;
		b[1] = coefs.b1;
		b[2] = coefs.b2;
		b[3] = coefs.b3;
		b[4] = coefs.b4;
		a[0] = '0;
		a[1] = coefs.a12[15:0];
		a[2] = coefs.a12[31:16];
		a[3] = coefs.a34[15:0];
		a[4] = coefs.a34[31:16];
		uu = longint'(u);
		acc = longint'(b[0]) * uu + longint'(tap_state[0]);
		// signed division truncates toward zero
		y = acc / (longint'(1) << coefs.frac);
		res.clipped = 1'b0;
		if (y > longint'(SAT_MAX)) begin
			y = longint'(SAT_MAX);
			res.clipped = 1'b1;
		end else if (y < longint'(SAT_MIN)) begin
			y = longint'(SAT_MIN);
			res.clipped = 1'b1;
		end
		for (int k = 1; k < ORDER; k++)
			tap_state[k-1] = STATE_WIDTH'(longint'(b[k]) * uu + longint'(tap_state[k])
				- longint'(a[k]) * y);
		tap_state[ORDER-1] = STATE_WIDTH'(longint'(b[ORDER]) * uu - longint'(a[ORDER]) * y);
		res.sample = SAMPLE_WIDTH'(y);
		pending_outputs.push_back(res);
	endtask

	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] u);
		int gap;
		gap = sender_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample_in <= u;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		predict_section_output(u);
	endtask

	// State updates run on after the result leaves, so settle before reconfiguring.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_coefs(input cfg_t c);
		logic [CFG_DATA_WIDTH-1:0] word [NUM_REGS];
		reg_idx_t r;
		word[REG_B0]    = {16'h0000, c.b0};
		word[REG_B1]    = {16'h0000, c.b1};
		word[REG_B2]    = {16'h0000, c.b2};
		word[REG_B3]    = {16'h0000, c.b3};
		word[REG_B4]    = {16'h0000, c.b4};
		word[REG_A1_A2] = c.a12;
		word[REG_A3_A4] = c.a34;
		word[REG_FRAC]  = {28'h0000000, c.frac};
		r = r.first();
		forever begin
			cfg_we    <= 1'b1;
			cfg_index <= r;
			cfg_wdata <= word[r];
			@(posedge clk);
			if (r == r.last())
				break;
			r = r.next();
		end
		cfg_we <= 1'b0;
		coefs = c;
	endtask

	task automatic test_reset_lowpass_extremes();
		send_sample(16'sh7FFF);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sh5555);
		send_sample(16'shAAAA);
		wait_drained();
	endtask

	task automatic test_rounding_and_saturation();
		cfg_t c;
		c = '0;
		c.b0 = 16'sd1;
		c.frac = 4'd4;
		load_coefs(c);
		// negative accumulators must round toward zero
		send_sample(-16'sd1);
		send_sample(-16'sd15);
		send_sample(-16'sd16);
		send_sample(-16'sd17);
		send_sample(16'sd17);
		wait_drained();
		c.b0 = 16'sh7FFF;
		c.frac = 4'd0;
		load_coefs(c);
		send_sample(16'sd1);
		send_sample(16'sd2);
		send_sample(-16'sd1);
		send_sample(-16'sd2);
		wait_drained();
	endtask

	task automatic test_saturated_feedback();
		cfg_t c;
		c.b0 = 16'sh7FFF;
		c.b1 = 16'sh7FFF;
		c.b2 = 16'sh7FFF;
		c.b3 = 16'sh7FFF;
		c.b4 = 16'sh7FFF;
		c.a12 = 32'h8000_8000;
		c.a34 = 32'h8000_8000;
		c.frac = 4'd0;
		load_coefs(c);
		repeat (5) send_sample(16'sh7FFF);
		repeat (5) send_sample(16'sh8000);
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		load_coefs(lowpass_coefs());
		sender_idle = 1'b0;
		receiver_idle = 1'b1;
		long_hold = LONG_HOLD_CYCLES;
		repeat (BURST_ITEMS) send_sample(SAMPLE_WIDTH'($urandom()));
		wait_drained();
	endtask

	task automatic test_random_phases();
		coef_style_t styles [7] = '{STYLE_LOWPASS, STYLE_WILD, STYLE_MILD, STYLE_EXTREME,
			STYLE_FIR, STYLE_MILD, STYLE_WILD};
		logic signed [SAMPLE_WIDTH-1:0] u;
		u = '0;
		foreach (styles[p]) begin
			load_coefs(random_coefs(styles[p]));
			sender_idle = (p != 0) && ($urandom_range(0, 3) != 0);
			receiver_idle = (p != 0) && ($urandom_range(0, 3) != 0);
			repeat (PHASE_ITEMS) begin
				u = random_sample(u);
				send_sample(u);
			end
			wait_drained();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.sample_in <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_B0;
		cfg_wdata <= '0;
		coefs = lowpass_coefs();
		foreach (tap_state[i])
			tap_state[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_lowpass_extremes();
		test_rounding_and_saturation();
		test_saturated_feedback();
		test_output_backpressure();
		test_random_phases();

		wait_drained();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result sink: random stalls, plus one long hold when requested
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold > 0) begin
				stall = long_hold;
				long_hold = 0;
			end else begin
				stall = receiver_idle ? $urandom_range(0, 8) : 0;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction: sample_out=%0d clipped=%0b",
					out_ch.sample_out, out_ch.clipped));
			end else begin
				want = pending_outputs.pop_front();
				if (out_ch.sample_out !== want.sample)
					report_mismatch($sformatf("sample_out=%0d, want %0d",
						out_ch.sample_out, want.sample));
				if (out_ch.clipped !== want.clipped)
					report_mismatch($sformatf("clipped=%0b, want %0b (sample %0d)",
						out_ch.clipped, want.clipped, want.sample));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

endmodule

// ----- sim.f -----
+incdir+src
src/fpiir_pkg.sv
src/fpiir_if.sv
src/fpiir_regs.sv
src/fpiir_dp.sv
src/fpiir_ctrl.sv
src/fixed_point_iir_section.sv
tb/tb.sv
